/* hw/rtl/cbb_pkg.sv */
package cbb_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 7;

   localparam int DIM_W   = 11;
   localparam int POS_W   = 10;
   localparam int RAD_W   = 3;
   localparam int SUM_W   = 16;
   localparam int DEN_W   = 8;
   localparam int PIX_W   = 24;
   localparam int DIFF_W  = 21;
   localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int RAM_DEPTH   = 1 << STORE_AW;
   localparam int DIV_CELLS   = SUM_W;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic       drain;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic                        valid;
      logic [2:0][SUM_W-1:0]       num;
      logic [2:0][DEN_W-1:0]       rem;
      logic [2:0][SUM_W-1:0]       quo;
      logic [DEN_W-1:0]            den;
   } div_stage_type;

endpackage

/* hw/rtl/cbb_ram.sv */
module cbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hw/rtl/cbb_div_cell.sv */
module cbb_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  cbb_pkg::div_stage_type stage_in,
   output cbb_pkg::div_stage_type stage_out
);
   import cbb_pkg::*;

   div_stage_type stage_in_next;
   div_stage_type stage_ff;

   always_comb begin
      logic [DEN_W:0] trial;
      logic           qbit;
      stage_in_next = stage_in;
      for (int ch = 0; ch < 3; ch++) begin
         trial = {stage_in.rem[ch], stage_in.num[ch][SUM_W-1]};
         qbit  = (trial >= {1'b0, stage_in.den});
         if (qbit) begin
            stage_in_next.rem[ch] = DEN_W'(trial - {1'b0, stage_in.den});
         end else begin
            stage_in_next.rem[ch] = trial[DEN_W-1:0];
         end
         stage_in_next.num[ch] = {stage_in.num[ch][SUM_W-2:0], 1'b0};
         stage_in_next.quo[ch] = {stage_in.quo[ch][SUM_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;
endmodule

/* hw/rtl/clipped_box_blur_rgb.sv */
// channel  direction  handshake             payload
// req      in         req_valid/req_ready   req_payload (rgb pixel, drain)
// rsp      out        rsp_valid/rsp_ready   rsp_payload (rgb mean, frame_last)
// csr      in         csr_we                csr_index, csr_wdata
//
// an item that gives no result is taken in ST_IDLE, and the block stays idle
// an item with a result passes ST_SETUP, ST_SUM, ST_TAIL, ST_FEED, ST_DIV and ST_OUT;
// the window is summed one pixel a cycle through the line store read port, then a 16-cell divider
// reset is synchronous, active high; the line store is not cleared
// a held result stalls the next result, and no input is accepted while that one waits
module clipped_box_blur_rgb (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbb_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbb_pkg::rsp_type  rsp_payload,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [10:0]       csr_wdata
);
   import cbb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_SUM, ST_TAIL, ST_FEED, ST_DIV, ST_OUT
   } state_type;

   state_type             state_ff;
   logic [DIM_W-1:0]      width_ff, height_ff;
   logic [RAD_W-1:0]      radius_ff;
   logic [DIM_W-1:0]      in_row_ff;
   logic [POS_W-1:0]      in_col_ff, out_row_ff, out_col_ff;
   logic [STORE_AW-1:0]   wp_ff, op_ff, addr_ff, row_adv_ff;
   logic [DIFF_W-1:0]     diff_ff;
   logic [3:0]            nr_ff, nc_ff, ri_ff, ci_ff;
   logic [DEN_W-1:0]      cnt_ff;
   logic                  last_ff, rd_v_ff;
   logic [2:0][SUM_W-1:0] acc_ff;
   logic [2:0][7:0]       res_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [DIM_W-1:0]      w_eff, h_eff;
   logic [DIFF_W-1:0]     lag;
   logic                  accept, in_done, emit, cfg_hit;
   logic [DIM_W-1:0]      up_row, up_col, below, right;
   logic [RAD_W-1:0]      du, dn, dl, dr;
   logic [3:0]            nr, nc;
   logic [PIX_W-1:0]      rd_data;
   logic                  ram_we;
   div_stage_type         chain [DIV_CELLS+1];

   assign w_eff = (width_ff == '0) ? DIM_W'(1) :
                  (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? DIM_W'(1) :
                  (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;
   assign lag   = DIFF_W'(radius_ff * w_eff) + DIFF_W'(radius_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_done   = (in_row_ff >= h_eff);
   assign emit      = in_done || (!req_payload.drain && (diff_ff >= lag));
   assign ram_we    = accept && !in_done && !req_payload.drain;
   assign cfg_hit   = csr_we && (csr_index inside {CSR_WIDTH, CSR_HEIGHT, CSR_RADIUS});

   // window bounds, clipped to the image
   assign up_row = {1'b0, out_row_ff};
   assign up_col = {1'b0, out_col_ff};
   assign below  = h_eff - DIM_W'(1) - up_row;
   assign right  = w_eff - DIM_W'(1) - up_col;
   assign du = (up_row >= DIM_W'(radius_ff)) ? radius_ff : up_row[RAD_W-1:0];
   assign dl = (up_col >= DIM_W'(radius_ff)) ? radius_ff : up_col[RAD_W-1:0];
   assign dn = (below >= DIM_W'(radius_ff)) ? radius_ff : below[RAD_W-1:0];
   assign dr = (right >= DIM_W'(radius_ff)) ? radius_ff : right[RAD_W-1:0];
   assign nr = 4'(du) + 4'(dn) + 4'd1;
   assign nc = 4'(dl) + 4'(dr) + 4'd1;

   cbb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (RAM_DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata ({req_payload.pixel_red, req_payload.pixel_green, req_payload.pixel_blue}),
      .raddr (addr_ff),
      .rdata (rd_data)
   );

   always_comb begin
      chain[0].valid = (state_ff == ST_FEED);
      chain[0].num   = acc_ff;
      chain[0].rem   = '0;
      chain[0].quo   = '0;
      chain[0].den   = cnt_ff;
   end

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      cbb_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= DIM_W'(1024);
         height_ff    <= DIM_W'(1024);
         radius_ff    <= RAD_W'(6);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         wp_ff        <= '0;
         op_ff        <= '0;
         diff_ff      <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff <= (state_ff == ST_SUM);
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT || cfg_hit)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_v_ff) begin
            for (int ch = 0; ch < 3; ch++) begin
               acc_ff[ch] <= acc_ff[ch] + SUM_W'(rd_data[(2-ch)*8 +: 8]);
            end
         end
         if (cfg_hit) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               CSR_RADIUS: radius_ff <= csr_wdata[RAD_W-1:0];
               default:    ;
            endcase
            in_row_ff  <= '0;
            in_col_ff  <= '0;
            out_row_ff <= '0;
            out_col_ff <= '0;
            wp_ff      <= '0;
            op_ff      <= '0;
            diff_ff    <= '0;
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  if (accept && !(in_done == 1'b0 && req_payload.drain)) begin
                     if (!in_done) begin
                        wp_ff <= wp_ff + STORE_AW'(1);
                        diff_ff <= diff_ff + DIFF_W'(1) - DIFF_W'(emit);
                        if ({1'b0, in_col_ff} == w_eff - DIM_W'(1)) begin
                           in_col_ff <= '0;
                           in_row_ff <= in_row_ff + DIM_W'(1);
                        end else begin
                           in_col_ff <= in_col_ff + POS_W'(1);
                        end
                     end
                     if (emit) begin
                        state_ff <= ST_SETUP;
                     end
                  end
               end
               ST_SETUP: begin
                  nr_ff      <= nr;
                  nc_ff      <= nc;
                  ri_ff      <= '0;
                  ci_ff      <= '0;
                  cnt_ff     <= DEN_W'(nr * nc);
                  addr_ff    <= op_ff - STORE_AW'(du * w_eff) - STORE_AW'(dl);
                  row_adv_ff <= STORE_AW'(w_eff - DIM_W'(nc) + DIM_W'(1));
                  last_ff    <= (up_row == h_eff - DIM_W'(1)) &&
                                (up_col == w_eff - DIM_W'(1));
                  acc_ff     <= '0;
                  state_ff   <= ST_SUM;
               end
               ST_SUM: begin
                  if (ci_ff == nc_ff - 4'd1) begin
                     ci_ff   <= '0;
                     ri_ff   <= ri_ff + 4'd1;
                     addr_ff <= addr_ff + row_adv_ff;
                     if (ri_ff == nr_ff - 4'd1) begin
                        state_ff <= ST_TAIL;
                     end
                  end else begin
                     ci_ff   <= ci_ff + 4'd1;
                     addr_ff <= addr_ff + STORE_AW'(1);
                  end
               end
               ST_TAIL: begin
                  state_ff <= ST_FEED;
               end
               ST_FEED: begin
                  state_ff <= ST_DIV;
               end
               ST_DIV: begin
                  if (chain[DIV_CELLS].valid) begin
                     for (int ch = 0; ch < 3; ch++) begin
                        res_ff[ch] <= chain[DIV_CELLS].quo[ch][7:0];
                     end
                     state_ff <= ST_OUT;
                  end
               end
               ST_OUT: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_ff.out_red     <= res_ff[0];
                     rsp_ff.out_green   <= res_ff[1];
                     rsp_ff.out_blue    <= res_ff[2];
                     rsp_ff.frame_last  <= last_ff;
                     if (last_ff) begin
                        in_row_ff  <= '0;
                        in_col_ff  <= '0;
                        out_row_ff <= '0;
                        out_col_ff <= '0;
                        wp_ff      <= '0;
                        op_ff      <= '0;
                        diff_ff    <= '0;
                     end else begin
                        op_ff <= op_ff + STORE_AW'(1);
                        if ({1'b0, out_col_ff} == w_eff - DIM_W'(1)) begin
                           out_col_ff <= '0;
                           out_row_ff <= out_row_ff + POS_W'(1);
                        end else begin
                           out_col_ff <= out_col_ff + POS_W'(1);
                        end
                     end
                     state_ff <= ST_IDLE;
                  end
               end
               default: begin
                  state_ff <= ST_IDLE;
               end
            endcase
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_read_in_sum: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> (state_ff == ST_SUM || state_ff == ST_TAIL))
      else $error("line store read outside window summation");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      chain[DIV_CELLS].valid |-> state_ff == ST_DIV)
      else $error("divider result outside wait state");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_valid_ff && !csr_we) |=> rsp_valid_ff)
      else $error("free output register not loaded");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input accepted while busy");
endmodule
